// ===== sv/ffa_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// No dependencies; the other files that use it refer to it by scoped names.
package ffa_pkg;

   localparam int HEAP_GRANULES_DEF = 512;

   // field widths
   localparam int FUNC_W = 1;
   localparam int REQ_W  = 13;
   localparam int OFF_W  = 13;
   localparam int ST_W   = 2;

   // 8-byte granules, one granule of header per block
   localparam int GRANULE_SHIFT = 3;
   localparam int ROUND_ADD     = (2 << GRANULE_SHIFT) - 1;
   localparam int NEED_W        = REQ_W + 1 - GRANULE_SHIFT;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   localparam logic [ST_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [ST_W-1:0] STATUS_NOFIT  = 2'd1;
   localparam logic [ST_W-1:0] STATUS_BADOFF = 2'd2;

   typedef struct packed {
      logic [OFF_W-1:0] data_offset;
      logic [ST_W-1:0]  status;
   } result_type;

endpackage

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator over an implicit block list of 8-byte granules.
// Block headers live in one RAM of HEAP_GRANULES entries with a registered
// read; a request reads the headers in address order, one block per cycle.
// A new request is taken only once the previous one has handed its result to
// the output register; an allocate that splits a block or a free that finds a
// successor block passes through a further state before that.
// Exactly one result is returned per request on the rsp_ channel. The output
// register lets a new request start while the previous result waits.
// No clearing pass is needed after reset.
// Depends on ffa_pkg, ffa_walk, ffa_out, ffa_ram.
module first_fit_heap_allocator #(
   parameter int HEAP_GRANULES = ffa_pkg::HEAP_GRANULES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ffa_pkg::FUNC_W-1:0]    req_func,
   input  logic [ffa_pkg::REQ_W-1:0]     req_request_bytes,
   input  logic [ffa_pkg::OFF_W-1:0]     req_free_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ffa_pkg::OFF_W-1:0]     rsp_data_offset,
   output logic [ffa_pkg::ST_W-1:0]      rsp_status
);

   logic                res_valid;
   logic                res_ready;
   ffa_pkg::result_type res;

   ffa_walk #(
      .HEAP_GRANULES (HEAP_GRANULES)
   ) u_walk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_request_bytes (req_request_bytes),
      .req_free_offset   (req_free_offset),
      .res_valid         (res_valid),
      .res               (res),
      .res_ready         (res_ready)
   );

   ffa_out u_out (
      .clock           (clock),
      .reset           (reset),
      .res_valid       (res_valid),
      .res             (res),
      .res_ready       (res_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_offset (rsp_data_offset),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== sv/ffa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/ffa_walk.sv =====
// Request sequencer: walks the block headers in the header RAM one per cycle,
// then splits, marks or merges blocks. Depends on ffa_pkg and ffa_ram.
module ffa_walk #(
   parameter int HEAP_GRANULES = ffa_pkg::HEAP_GRANULES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ffa_pkg::FUNC_W-1:0]     req_func,
   input  logic [ffa_pkg::REQ_W-1:0]      req_request_bytes,
   input  logic [ffa_pkg::OFF_W-1:0]      req_free_offset,
   output logic                           res_valid,
   output ffa_pkg::result_type            res,
   input  logic                           res_ready
);

   localparam int GW = $clog2(HEAP_GRANULES);
   localparam int SW = $clog2(HEAP_GRANULES + 1);
   localparam int HW = SW + 1;
   localparam int NW = ffa_pkg::NEED_W;
   localparam int CW = (SW > NW) ? SW : NW;
   localparam int PW = CW + 1;
   localparam int BW = PW + ffa_pkg::GRANULE_SHIFT;
   localparam int AW = (BW > ffa_pkg::OFF_W) ? BW : ffa_pkg::OFF_W;

   localparam logic [PW-1:0] HEAP_P    = PW'(HEAP_GRANULES);
   localparam logic [HW-1:0] RESET_HDR = {SW'(HEAP_GRANULES), 1'b0};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_ALLOC_HEAD,
      ST_FREE_NEXT,
      ST_RESP
   } state_type;

   state_type                   state_ff, state_in;
   logic                        init0_ff, init0_in;
   logic [ffa_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic [NW-1:0]               need_ff, need_in;
   logic [ffa_pkg::OFF_W-1:0]   offset_ff, offset_in;
   logic [GW-1:0]               g_ff, g_in;
   logic [GW-1:0]               prev_g_ff, prev_g_in;
   logic [HW-1:0]               prev_hdr_ff, prev_hdr_in;
   logic                        have_prev_ff, have_prev_in;
   logic [GW-1:0]               base_ff, base_in;
   logic [SW-1:0]               size_ff, size_in;
   ffa_pkg::result_type         res_ff, res_in;

   logic                        wr_en, rd_en;
   logic [GW-1:0]               wr_addr, rd_addr;
   logic [HW-1:0]               wr_data, rd_data;

   logic [ffa_pkg::REQ_W:0]     round_sum;
   logic [HW-1:0]               hdr;
   logic [PW-1:0]               s_p, g_p, need_p, room, nx_p, prev_s_p;
   logic                        used, broken, at_end, fit, split, match, merge_prev;
   logic [BW-1:0]               data_pos;

   ffa_ram #(
      .WIDTH (HW),
      .DEPTH (HEAP_GRANULES)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry 0 holds the whole-heap free block until it is first written
   assign hdr = (g_ff == '0 && !init0_ff) ? RESET_HDR : rd_data;

   assign round_sum = {1'b0, req_request_bytes} + (ffa_pkg::REQ_W+1)'(ffa_pkg::ROUND_ADD);

   assign s_p      = PW'(hdr[HW-1:1]);
   assign used     = hdr[0];
   assign g_p      = PW'(g_ff);
   assign need_p   = PW'(need_ff);
   assign room     = HEAP_P - g_p;
   assign broken   = (s_p == '0) || (s_p > room);
   assign nx_p     = broken ? HEAP_P : (g_p + s_p);
   assign at_end   = (nx_p == HEAP_P);
   assign fit      = !used && (s_p >= need_p) && !broken;
   assign split    = (s_p > need_p);
   assign data_pos = {g_p + PW'(1), {ffa_pkg::GRANULE_SHIFT{1'b0}}};
   assign match    = (AW'(data_pos) == AW'(offset_ff));
   assign prev_s_p = PW'(prev_hdr_ff[HW-1:1]);
   assign merge_prev = have_prev_ff && !prev_hdr_ff[0];

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_RESP);
   assign res       = res_ff;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      need_in      = need_ff;
      offset_in    = offset_ff;
      g_in         = g_ff;
      prev_g_in    = prev_g_ff;
      prev_hdr_in  = prev_hdr_ff;
      have_prev_in = have_prev_ff;
      base_in      = base_ff;
      size_in      = size_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = g_ff;
      wr_data      = hdr;
      rd_en        = 1'b0;
      rd_addr      = GW'(nx_p);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in      = req_func;
               need_in      = round_sum[ffa_pkg::REQ_W:ffa_pkg::GRANULE_SHIFT];
               offset_in    = req_free_offset;
               g_in         = '0;
               have_prev_in = 1'b0;
               rd_en        = 1'b1;
               rd_addr      = '0;
               state_in     = ST_WALK;
            end
         end
         ST_WALK: begin
            if (func_ff == ffa_pkg::FUNC_ALLOC) begin
               if (fit) begin
                  wr_en = 1'b1;
                  res_in.data_offset = ffa_pkg::OFF_W'(data_pos);
                  res_in.status      = ffa_pkg::STATUS_OK;
                  if (split) begin
                     // remainder header first, own header next cycle
                     wr_addr  = GW'(g_p + need_p);
                     wr_data  = {SW'(s_p - need_p), 1'b0};
                     state_in = ST_ALLOC_HEAD;
                  end else begin
                     wr_data  = {SW'(s_p), 1'b1};
                     state_in = ST_RESP;
                  end
               end else if (at_end) begin
                  res_in.data_offset = '0;
                  res_in.status      = ffa_pkg::STATUS_NOFIT;
                  state_in           = ST_RESP;
               end else begin
                  rd_en = 1'b1;
                  g_in  = GW'(nx_p);
               end
            end else begin
               if (match) begin
                  base_in = merge_prev ? prev_g_ff : g_ff;
                  size_in = merge_prev ? SW'(s_p + prev_s_p) : SW'(s_p);
                  res_in.data_offset = '0;
                  res_in.status      = ffa_pkg::STATUS_OK;
                  if (at_end) begin
                     wr_en    = 1'b1;
                     wr_addr  = base_in;
                     wr_data  = {size_in, 1'b0};
                     state_in = ST_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     g_in     = GW'(nx_p);
                     state_in = ST_FREE_NEXT;
                  end
               end else if (at_end) begin
                  res_in.data_offset = '0;
                  res_in.status      = ffa_pkg::STATUS_BADOFF;
                  state_in           = ST_RESP;
               end else begin
                  prev_g_in    = g_ff;
                  prev_hdr_in  = hdr;
                  have_prev_in = 1'b1;
                  rd_en        = 1'b1;
                  g_in         = GW'(nx_p);
               end
            end
         end
         ST_ALLOC_HEAD: begin
            wr_en    = 1'b1;
            wr_data  = {SW'(need_p), 1'b1};
            state_in = ST_RESP;
         end
         ST_FREE_NEXT: begin
            // successor header is on the read port now
            wr_en    = 1'b1;
            wr_addr  = base_ff;
            wr_data  = used ? {size_ff, 1'b0} : {SW'(PW'(size_ff) + s_p), 1'b0};
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      init0_in = init0_ff || (wr_en && wr_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         init0_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init0_ff <= init0_in;
      end
      func_ff      <= func_in;
      need_ff      <= need_in;
      offset_ff    <= offset_in;
      g_ff         <= g_in;
      prev_g_ff    <= prev_g_in;
      prev_hdr_ff  <= prev_hdr_in;
      have_prev_ff <= have_prev_in;
      base_ff      <= base_in;
      size_ff      <= size_in;
      res_ff       <= res_in;
   end

endmodule

// ===== sv/ffa_out.sv =====
// Result output register: holds one result for the rsp_ channel so the
// sequencer can take the next request. Depends on ffa_pkg.
module ffa_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   input  ffa_pkg::result_type           res,
   output logic                          res_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ffa_pkg::OFF_W-1:0]     rsp_data_offset,
   output logic [ffa_pkg::ST_W-1:0]      rsp_status
);

   logic                rsp_valid_ff, rsp_valid_in;
   ffa_pkg::result_type data_ff, data_in;

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_valid && res_ready) begin
         data_in      = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_offset = data_ff.data_offset;
   assign rsp_status      = data_ff.status;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_heap_allocator: allocate/free traffic
// checked against a local first-fit heap predictor. Depends on ffa_pkg and first_fit_heap_allocator.
module testbench;

   localparam int unsigned HEAP_N       = ffa_pkg::HEAP_GRANULES_DEF;
   localparam int unsigned DIRECTED_N   = 23;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 600;

   typedef struct {
      logic [ffa_pkg::FUNC_W-1:0] func;
      logic [ffa_pkg::REQ_W-1:0]  req_bytes;
      logic [ffa_pkg::OFF_W-1:0]  offset;
      bit                         known;
      ffa_pkg::result_type        result;
   } stim_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [ffa_pkg::FUNC_W-1:0] req_func;
   logic [ffa_pkg::REQ_W-1:0]  req_request_bytes;
   logic [ffa_pkg::OFF_W-1:0]  req_free_offset;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [ffa_pkg::OFF_W-1:0]  rsp_data_offset;
   logic [ffa_pkg::ST_W-1:0]   rsp_status;

   // predictor state: used flag in bit 0, block size in granules above it
   bit [10:0]                  heap_hdr [HEAP_N];
   ffa_pkg::result_type        pending_results [$];
   ffa_pkg::result_type        oldest_result;
   logic [ffa_pkg::OFF_W-1:0]  live_offsets [$];
   logic [ffa_pkg::OFF_W-1:0]  freed_offsets [$];
   int unsigned                error_count;
   int unsigned                send_idle_pct;
   int unsigned                stall_pct;
   bit                         hold_request;
   bit                         rsp_hold;

   // heap starts as one free block; rows without a typed result use the predictor
   stim_row_type directed_rows [DIRECTED_N] = '{
      '{ffa_pkg::FUNC_ALLOC, 13'd0,    13'd0,    1'b1, '{13'd8,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_ALLOC, 13'd8191, 13'd0,    1'b1, '{13'd0,    ffa_pkg::STATUS_NOFIT}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd0,    1'b1, '{13'd0,    ffa_pkg::STATUS_BADOFF}},
      '{ffa_pkg::FUNC_FREE,  13'd8191, 13'd8191, 1'b1, '{13'd0,    ffa_pkg::STATUS_BADOFF}},
      '{ffa_pkg::FUNC_ALLOC, 13'd4072, 13'd8191, 1'b1, '{13'd16,   ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_ALLOC, 13'd0,    13'd0,    1'b1, '{13'd4096, ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_ALLOC, 13'd1,    13'd0,    1'b1, '{13'd0,    ffa_pkg::STATUS_NOFIT}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd4096, 1'b1, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd4096, 1'b1, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd16,   1'b1, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd8,    1'b1, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_ALLOC, 13'd4088, 13'd0,    1'b1, '{13'd8,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_ALLOC, 13'd0,    13'd0,    1'b1, '{13'd0,    ffa_pkg::STATUS_NOFIT}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd8,    1'b1, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_ALLOC, 13'd4089, 13'd0,    1'b1, '{13'd0,    ffa_pkg::STATUS_NOFIT}},
      '{ffa_pkg::FUNC_ALLOC, 13'd100,  13'd0,    1'b0, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_ALLOC, 13'd200,  13'd0,    1'b0, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_ALLOC, 13'd50,   13'd0,    1'b0, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd120,  1'b0, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd8,    1'b0, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd12,   1'b1, '{13'd0,    ffa_pkg::STATUS_BADOFF}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd328,  1'b0, '{13'd0,    ffa_pkg::STATUS_OK}},
      '{ffa_pkg::FUNC_FREE,  13'd0,    13'd16,   1'b1, '{13'd0,    ffa_pkg::STATUS_BADOFF}}
   };

   first_fit_heap_allocator uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_request_bytes (req_request_bytes),
      .req_free_offset   (req_free_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_status        (rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int unsigned blk_size(int unsigned g);
      return int'(heap_hdr[g][10:1]);
   endfunction

   function automatic bit blk_used(int unsigned g);
      return heap_hdr[g][0];
   endfunction

   function automatic void set_blk(int unsigned g, int unsigned size, bit used);
      heap_hdr[g] = {10'(size), used};
   endfunction

   // broken or final header ends the walk as if at the heap end
   function automatic int unsigned next_blk(int unsigned g);
      int unsigned s;
      s = blk_size(g);
      if (s == 0 || s > HEAP_N - g)
         return HEAP_N;
      return g + s;
   endfunction

   function automatic ffa_pkg::result_type heap_request(
         logic [ffa_pkg::FUNC_W-1:0] func,
         logic [ffa_pkg::REQ_W-1:0]  req_bytes,
         logic [ffa_pkg::OFF_W-1:0]  offset);
      ffa_pkg::result_type res;
      int unsigned         g;
      int unsigned         prev;
      int unsigned         need;
      int unsigned         sz;
      int unsigned         base;
      int unsigned         nx;
      bit                  have_prev;
      res.data_offset = '0;
      g = 0;
      prev = 0;
      have_prev = 1'b0;
      if (func == ffa_pkg::FUNC_ALLOC) begin
         res.status = ffa_pkg::STATUS_NOFIT;
         need = (int'(req_bytes) + ffa_pkg::ROUND_ADD) >> ffa_pkg::GRANULE_SHIFT;
         while (g < HEAP_N) begin
            sz = blk_size(g);
            if (!blk_used(g) && sz >= need && sz != 0 && sz <= HEAP_N - g) begin
               if (sz > need) begin
                  set_blk(g + need, sz - need, 1'b0);
                  set_blk(g, need, 1'b1);
               end else begin
                  set_blk(g, sz, 1'b1);
               end
               res.data_offset = ffa_pkg::OFF_W'((g + 1) << ffa_pkg::GRANULE_SHIFT);
               res.status = ffa_pkg::STATUS_OK;
               break;
            end
            g = next_blk(g);
         end
      end else begin
         res.status = ffa_pkg::STATUS_BADOFF;
         while (g < HEAP_N) begin
            if (((g + 1) << ffa_pkg::GRANULE_SHIFT) == int'(offset)) begin
               base = g;
               sz = blk_size(g);
               nx = next_blk(g);
               if (have_prev && !blk_used(prev)) begin
                  base = prev;
                  sz += blk_size(prev);
               end
               if (nx < HEAP_N && !blk_used(nx))
                  sz += blk_size(nx);
               set_blk(base, sz, 1'b0);
               res.status = ffa_pkg::STATUS_OK;
               break;
            end
            prev = g;
            have_prev = 1'b1;
            g = next_blk(g);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // called at a rising edge; returns at the edge where the transfer happens
   task automatic send_request(logic [ffa_pkg::FUNC_W-1:0] func,
                               logic [ffa_pkg::REQ_W-1:0]  req_bytes,
                               logic [ffa_pkg::OFF_W-1:0]  offset);
      bit taken;
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_request_bytes <= req_bytes;
      req_free_offset   <= offset;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic run_random(int unsigned count);
      logic [ffa_pkg::FUNC_W-1:0] func;
      logic [ffa_pkg::REQ_W-1:0]  req_bytes;
      logic [ffa_pkg::OFF_W-1:0]  offset;
      int unsigned                pick;
      int unsigned                idx;
      ffa_pkg::result_type        res;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         // the field the operation ignores still carries random bits
         req_bytes = ffa_pkg::REQ_W'($urandom);
         offset = ffa_pkg::OFF_W'($urandom);
         if (pick < 42 || live_offsets.size() == 0) begin
            func = ffa_pkg::FUNC_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 70)
               req_bytes = ffa_pkg::REQ_W'($urandom_range(0, 64));
            else if (pick < 90)
               req_bytes = ffa_pkg::REQ_W'($urandom_range(65, 512));
            else if (pick < 97)
               req_bytes = ffa_pkg::REQ_W'($urandom_range(513, 4096));
         end else if (pick < 86) begin
            func = ffa_pkg::FUNC_FREE;
            idx = $urandom_range(0, live_offsets.size() - 1);
            offset = live_offsets[idx];
            live_offsets.delete(idx);
            freed_offsets.push_back(offset);
            if (freed_offsets.size() > 32)
               void'(freed_offsets.pop_front());
         end else if (pick < 93) begin
            // stale or merged-away block starts
            func = ffa_pkg::FUNC_FREE;
            if (freed_offsets.size() != 0)
               offset = freed_offsets[$urandom_range(0, freed_offsets.size() - 1)];
            else
               offset = ffa_pkg::OFF_W'($urandom_range(0, HEAP_N) << ffa_pkg::GRANULE_SHIFT);
         end else begin
            func = ffa_pkg::FUNC_FREE;
         end
         send_request(func, req_bytes, offset);
         res = heap_request(func, req_bytes, offset);
         if (func == ffa_pkg::FUNC_ALLOC && res.status == ffa_pkg::STATUS_OK)
            live_offsets.push_back(res.data_offset);
         pending_results.push_back(res);
      end
   endtask

   // result side: random stall plus one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= rsp_hold || ($urandom_range(1, 100) <= stall_pct);
      end
   end

   initial begin
      rsp_hold = 1'b0;
      wait (hold_request);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // outputs are stable at the falling edge, so a transfer seen here is certain
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer: offset %0d status %0d",
                                      rsp_data_offset, rsp_status));
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data_offset !== oldest_result.data_offset)
               report_mismatch($sformatf("data_offset %0d, expected %0d",
                                         rsp_data_offset, oldest_result.data_offset));
            if (rsp_status !== oldest_result.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, oldest_result.status));
         end
      end
   end

   initial begin
      ffa_pkg::result_type res;
      error_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = ffa_pkg::FUNC_ALLOC;
      req_request_bytes = '0;
      req_free_offset = '0;
      heap_hdr[0] = {10'(HEAP_N), 1'b0};
      for (int unsigned g = 1; g < HEAP_N; g++)
         heap_hdr[g] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int unsigned i = 0; i < DIRECTED_N; i++) begin
         send_request(directed_rows[i].func, directed_rows[i].req_bytes,
                      directed_rows[i].offset);
         res = heap_request(directed_rows[i].func, directed_rows[i].req_bytes,
                            directed_rows[i].offset);
         pending_results.push_back(directed_rows[i].known ? directed_rows[i].result : res);
      end

      // back-to-back, with the receiver held off long enough to fill the block
      hold_request = 1'b1;
      run_random(300);
      send_idle_pct = 71;
      run_random(350);
      send_idle_pct = 0;
      stall_pct = 71;
      run_random(350);
      send_idle_pct = 29;
      stall_pct = 29;
      run_random(350);
      req_valid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
